FILE: rtl/ucpt_pkg.sv
// Shared types and constants for the UTF-8 CJK/punctuation pretokenizer.
// No dependencies; imported by ucpt_front, ucpt_queue, ucpt_back, the top level and tb_top.
package ucpt_pkg;

  // Result kinds carried on the output tuser
  localparam logic [1:0] IT_BYTE      = 2'd0;
  localparam logic [1:0] IT_END_TOKEN = 2'd1;
  localparam logic [1:0] IT_END_TEXT  = 2'd2;

  // Slots of one run, emitted lowest first
  localparam int NSLOT      = 7;
  localparam int SLOT_PRE   = 0;  // end of token before the code point
  localparam int SLOT_B0    = 1;  // encoded bytes in slots 1..4
  localparam int SLOT_B1    = 2;
  localparam int SLOT_B2    = 3;
  localparam int SLOT_B3    = 4;
  localparam int SLOT_TAIL  = 5;  // end of token after the code point
  localparam int SLOT_ETEXT = 6;  // end of text

  // Code point width and special values
  localparam int          CP_W        = 21;
  localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One run of results for one input beat
  typedef struct packed {
    logic [NSLOT-1:0]  mask;   // slot present
    logic [3:0][7:0]   bytes;  // encoded bytes, index 0 first
  } desc_t;

endpackage

FILE: rtl/ucpt_front.sv
// Front end: UTF-8 decode state, code point classification and re-encoding.
// Depends on ucpt_pkg; feeds at most one run descriptor per input beat into ucpt_queue.
module ucpt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] in_byte
  input  logic          in_tlast,   // last_in_text
  input  logic          q_full,
  output logic          push_valid,
  output ucpt_pkg::desc_t push_desc
);
  import ucpt_pkg::*;

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      left_r, left_nxt;
  logic            inside_r, inside_nxt;

  logic            accept;
  logic [CP_W-1:0] pc_shift;
  logic [CP_W-1:0] pc_dec;
  logic [1:0]      left_dec;
  logic            go_dec;
  logic [CP_W-1:0] cp;
  logic            go;
  logic            is_space, is_cjk, is_punct, is_sep;
  logic            has_bytes, inside_after, fin_close;
  logic [2:0]      nbytes;
  logic [3:0][7:0] enc;
  logic [7:0]      low_byte;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign pc_shift  = {partial_r[CP_W-7:0], in_tdata[5:0]};

  // Decode one byte against the pending sequence
  always_comb begin
    pc_dec   = partial_r;
    left_dec = left_r;
    go_dec   = 1'b0;
    cp       = CP_REPLACE;
    if (left_r != 2'd0) begin
      pc_dec   = pc_shift;
      left_dec = left_r - 2'd1;
      go_dec   = (left_r == 2'd1);
      cp       = pc_shift;
    end else if (!in_tdata[7]) begin
      go_dec = 1'b1;
      cp     = {13'd0, in_tdata};
    end else if (in_tdata[7:5] == 3'b110) begin
      pc_dec   = {16'd0, in_tdata[4:0]};
      left_dec = 2'd1;
    end else if (in_tdata[7:4] == 4'b1110) begin
      pc_dec   = {17'd0, in_tdata[3:0]};
      left_dec = 2'd2;
    end else if (in_tdata[7:3] == 5'b11110) begin
      pc_dec   = {18'd0, in_tdata[2:0]};
      left_dec = 2'd3;
    end else begin
      go_dec = 1'b1;
      cp     = CP_REPLACE;
    end
  end

  // Sequence cut short by end of text becomes the replacement character
  always_comb begin
    go = go_dec;
    if (in_tlast && left_dec != 2'd0) begin
      go = 1'b1;
    end
  end

  logic [CP_W-1:0] cp_sel;
  assign cp_sel = (in_tlast && left_dec != 2'd0) ? CP_REPLACE : cp;

  // Classes
  assign is_space = (cp_sel >= 21'h09 && cp_sel <= 21'h0D) || cp_sel == 21'h20;
  assign is_cjk   = (cp_sel >= 21'h4E00  && cp_sel <= 21'h9FFF)  ||
                    (cp_sel >= 21'h3400  && cp_sel <= 21'h4DBF)  ||
                    (cp_sel >= 21'h20000 && cp_sel <= 21'h2A6DF) ||
                    (cp_sel >= 21'h2A700 && cp_sel <= 21'h2CEAF) ||
                    (cp_sel >= 21'hF900  && cp_sel <= 21'hFAFF)  ||
                    (cp_sel >= 21'h2F800 && cp_sel <= 21'h2FA1F);
  assign is_punct = (cp_sel >= 21'd33  && cp_sel <= 21'd47)  ||
                    (cp_sel >= 21'd58  && cp_sel <= 21'd64)  ||
                    (cp_sel >= 21'd91  && cp_sel <= 21'd96)  ||
                    (cp_sel >= 21'd123 && cp_sel <= 21'd126) ||
                    (cp_sel >= 21'h2000 && cp_sel <= 21'h206F) ||
                    (cp_sel >= 21'hFF00 && cp_sel <= 21'hFFEF);
  assign is_sep   = is_cjk || is_punct;

  // Shortest-form re-encoding, ASCII upper case lowered
  assign low_byte = (cp_sel[7:0] >= 8'h41 && cp_sel[7:0] <= 8'h5A) ?
                    cp_sel[7:0] + 8'h20 : cp_sel[7:0];
  always_comb begin
    enc = '0;
    if (cp_sel < 21'h80) begin
      nbytes = 3'd1;
      enc[0] = low_byte;
    end else if (cp_sel < 21'h800) begin
      nbytes = 3'd2;
      enc[0] = {3'b110, cp_sel[10:6]};
      enc[1] = {2'b10, cp_sel[5:0]};
    end else if (cp_sel < 21'h10000) begin
      nbytes = 3'd3;
      enc[0] = {4'b1110, cp_sel[15:12]};
      enc[1] = {2'b10, cp_sel[11:6]};
      enc[2] = {2'b10, cp_sel[5:0]};
    end else begin
      nbytes = 3'd4;
      enc[0] = {5'b11110, cp_sel[20:18]};
      enc[1] = {2'b10, cp_sel[17:12]};
      enc[2] = {2'b10, cp_sel[11:6]};
      enc[3] = {2'b10, cp_sel[5:0]};
    end
  end

  // Token bookkeeping
  assign has_bytes    = go && !is_space;
  assign inside_after = go ? !(is_space || is_sep) : inside_r;
  assign fin_close    = in_tlast && inside_after;

  // Run descriptor
  always_comb begin
    push_desc.bytes            = enc;
    push_desc.mask             = '0;
    push_desc.mask[SLOT_PRE]   = go && (is_space || is_sep) && inside_r;
    push_desc.mask[SLOT_B0]    = has_bytes;
    push_desc.mask[SLOT_B1]    = has_bytes && nbytes >= 3'd2;
    push_desc.mask[SLOT_B2]    = has_bytes && nbytes >= 3'd3;
    push_desc.mask[SLOT_B3]    = has_bytes && nbytes == 3'd4;
    push_desc.mask[SLOT_TAIL]  = (go && is_sep) || fin_close;
    push_desc.mask[SLOT_ETEXT] = in_tlast;
  end

  assign push_valid = accept && (push_desc.mask != '0);

  // Next decode state; end of text returns everything to zero
  always_comb begin
    partial_nxt = partial_r;
    left_nxt    = left_r;
    inside_nxt  = inside_r;
    if (accept) begin
      if (in_tlast) begin
        partial_nxt = '0;
        left_nxt    = 2'd0;
        inside_nxt  = 1'b0;
      end else begin
        partial_nxt = pc_dec;
        left_nxt    = left_dec;
        inside_nxt  = inside_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= 2'd0;
      inside_r  <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
      inside_r  <= inside_nxt;
    end
  end

endmodule

FILE: rtl/ucpt_queue.sv
// Short register queue of run descriptors between front and back.
// Depends on ucpt_pkg (desc_t, QDEPTH).
module ucpt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ucpt_pkg::desc_t push_desc,
  input  logic            pop,
  output ucpt_pkg::desc_t head,
  output logic            full,
  output logic            empty
);
  import ucpt_pkg::*;

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: rtl/ucpt_back.sv
// Back end: walks the slots of each run descriptor, one result beat per cycle while out_tready is high.
// Depends on ucpt_pkg; pops from ucpt_queue and drives the output register.
module ucpt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ucpt_pkg::desc_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [1:0] item_type
  output logic            out_tlast   // last_of_run
);
  import ucpt_pkg::*;

  logic [NSLOT-1:0] mask_r, mask_nxt;
  logic [3:0][7:0]  bytes_r;
  logic             valid_r, valid_nxt;
  logic [7:0]       data_r;
  logic [1:0]       user_r;
  logic             last_r;

  logic             advance, busy, load;
  logic [NSLOT-1:0] sel, rem;
  logic [7:0]       emit_data;
  logic [1:0]       emit_user;

  assign advance = !valid_r || out_tready;
  assign busy    = (mask_r != '0);
  assign sel     = mask_r & (~mask_r + NSLOT'(1));
  assign rem     = mask_r & ~sel;

  // Refill when idle, or right as the final slot leaves
  assign load = !empty && (!busy || (advance && rem == '0));
  assign pop  = load;

  // Lowest pending slot
  always_comb begin
    emit_data = 8'h00;
    emit_user = IT_BYTE;
    case (sel)
      NSLOT'(1) << SLOT_PRE:   emit_user = IT_END_TOKEN;
      NSLOT'(1) << SLOT_B0:    emit_data = bytes_r[0];
      NSLOT'(1) << SLOT_B1:    emit_data = bytes_r[1];
      NSLOT'(1) << SLOT_B2:    emit_data = bytes_r[2];
      NSLOT'(1) << SLOT_B3:    emit_data = bytes_r[3];
      NSLOT'(1) << SLOT_TAIL:  emit_user = IT_END_TOKEN;
      NSLOT'(1) << SLOT_ETEXT: emit_user = IT_END_TEXT;
      default: begin
        emit_data = 8'h00;
        emit_user = IT_BYTE;
      end
    endcase
  end

  // Slot mask and output valid
  always_comb begin
    mask_nxt  = mask_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = busy;
      if (busy) begin
        mask_nxt = rem;
      end
    end
    if (load) begin
      mask_nxt = head.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= head.bytes;
    end
    if (advance && busy) begin
      data_r <= emit_data;
      user_r <= emit_user;
      last_r <= (rem == '0);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

FILE: rtl/utf8_cjk_punct_pretokenizer.sv
// UTF-8 byte stream pretokenizer: whitespace split, CJK/punctuation isolation.
// An input beat's descriptor passes through a queue entry and the slot mask register to the output register.
// Throughput: one output beat per cycle while out_tready is high, set by the back-end slot sequencer; an input
// byte yields 0 to 7 output beats, so input runs one beat per cycle while runs are single.
// A 4-entry descriptor queue lets input continue while output is stalled, until the queue fills.
// Reset (rst_n low, synchronous) clears decode state, token state, queue and output valid.
module utf8_cjk_punct_pretokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_in_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] item_type
  output logic       out_tlast   // last_of_run
);
  import ucpt_pkg::*;

  logic  push_valid, q_full, q_empty, pop;
  desc_t push_desc, head;

  ucpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_desc  (push_desc)
  );

  ucpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ucpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // End of text always closes its run
  a_etext_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == IT_END_TEXT |-> out_tlast)
    else $error("end-of-text beat without tlast");

  // Marker beats carry zero data
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != IT_BYTE |-> out_tdata == 8'h00)
    else $error("marker beat with nonzero data");

  // A final text byte always queues a run ending in end of text
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |-> push_valid && push_desc.mask[SLOT_ETEXT])
    else $error("last text byte did not queue end of text");

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for utf8_cjk_punct_pretokenizer: drives UTF-8 text beats and
// checks every output beat against an in-bench tokenizer prediction.
// Depends on ucpt_pkg (result kinds, replacement code point) and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import ucpt_pkg::*;

  // One input beat: a text byte and its end-of-text flag
  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // One output beat: result kind, byte and end-of-run flag
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } token_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // last_in_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [1:0] out_tuser;          // [1:0] item_type
  logic       out_tlast;          // last_of_run

  text_beat_t  text_q[$];       // bytes still to send
  token_beat_t tokens_due[$];   // predicted output beats, oldest first
  token_beat_t run_buf[$];      // beats of the byte being predicted
  logic [7:0]  text_buf[$];     // text under construction

  // Predicted tokenizer state
  logic [20:0] acc_cp = '0;
  logic [1:0]  cont_left = '0;
  logic        tok_open = 1'b0;

  int errors = 0;
  int in_beats = 0;
  int beats_seen = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  logic calm;

  // No random idling on either side for a stretch in the middle of the run
  assign calm = (in_beats >= 70) && (in_beats < 120);

  utf8_cjk_punct_pretokenizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Shortest UTF-8 form; anything 0x10000 and up takes four bytes
  function automatic void utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] enc,
                                      output int n);
    enc = '0;
    if (cp < 21'h80) begin
      enc[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      n = 4;
    end
  endfunction

  function automatic bit is_space(input logic [20:0] cp);
    return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20;
  endfunction

  function automatic bit is_cjk(input logic [20:0] cp);
    return (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
           (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'h2A700 && cp <= 21'h2CEAF) ||
           (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'h2F800 && cp <= 21'h2FA1F);
  endfunction

  function automatic bit is_punct(input logic [20:0] cp);
    return (cp >= 21'd33 && cp <= 21'd47) || (cp >= 21'd58 && cp <= 21'd64) ||
           (cp >= 21'd91 && cp <= 21'd96) || (cp >= 21'd123 && cp <= 21'd126) ||
           (cp >= 21'h2000 && cp <= 21'h206F) || (cp >= 21'hFF00 && cp <= 21'hFFEF);
  endfunction

  function automatic void put_beat(input logic [1:0] kind, input logic [7:0] data);
    token_beat_t t;
    t.kind = kind;
    t.data = data;
    t.last = 1'b0;
    run_buf = {run_buf, t};
  endfunction

  function automatic void close_token();
    if (tok_open) begin
      put_beat(IT_END_TOKEN, 8'h00);
      tok_open = 1'b0;
    end
  endfunction

  function automatic void put_code_point(input logic [20:0] cp);
    logic [3:0][7:0] enc;
    int n;
    utf8_encode(cp, enc, n);
    // ASCII upper case is lowered
    if (n == 1 && enc[0] >= 8'h41 && enc[0] <= 8'h5A) enc[0] = enc[0] + 8'h20;
    for (int i = 0; i < n; i++) put_beat(IT_BYTE, enc[i]);
  endfunction

  // Whitespace closes; CJK and punctuation stand alone; the rest extends the token
  function automatic void take_code_point(input logic [20:0] cp);
    if (is_space(cp)) begin
      close_token();
    end else if (is_cjk(cp) || is_punct(cp)) begin
      close_token();
      put_code_point(cp);
      put_beat(IT_END_TOKEN, 8'h00);
    end else begin
      put_code_point(cp);
      tok_open = 1'b1;
    end
  endfunction

  // Predict the output beats of one accepted text byte
  function automatic void split_byte(input logic [7:0] b, input logic last);
    token_beat_t t;
    run_buf.delete();
    if (cont_left != 2'd0) begin
      // continuation bytes are taken by their low six bits, unchecked
      acc_cp = {acc_cp[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) take_code_point(acc_cp);
    end else if (b[7] == 1'b0) begin
      take_code_point({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      acc_cp = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_cp = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      acc_cp = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      take_code_point(CP_REPLACE);
    end
    // end of text: a cut-short sequence becomes one replacement, then markers
    if (last) begin
      if (cont_left != 2'd0) take_code_point(CP_REPLACE);
      close_token();
      put_beat(IT_END_TEXT, 8'h00);
      acc_cp = '0;
      cont_left = '0;
      tok_open = 1'b0;
    end
    for (int i = 0; i < run_buf.size(); i++) begin
      t = run_buf[i];
      t.last = (i == run_buf.size() - 1);
      tokens_due = {tokens_due, t};
    end
  endfunction

  // Move text_buf into the send queue, flagging its final byte as end of text
  task automatic flush_text();
    text_beat_t tb;
    for (int i = 0; i < text_buf.size(); i++) begin
      tb.data = text_buf[i];
      tb.last = (i == text_buf.size() - 1);
      text_q = {text_q, tb};
    end
    text_buf.delete();
  endtask

  task automatic add_cp(input logic [20:0] cp);
    logic [3:0][7:0] enc;
    int n;
    utf8_encode(cp, enc, n);
    for (int i = 0; i < n; i++) text_buf = {text_buf, enc[i]};
  endtask

  // One random text: mostly well-formed characters, some noise and cut-short tails
  task automatic add_random_text();
    int nchar;
    int r;
    logic [20:0] cp;
    nchar = $urandom_range(1, 10);
    for (int c = 0; c < nchar; c++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        cp = 21'($urandom_range(0, 127));
      end else if (r < 40) begin
        cp = ($urandom_range(0, 1) != 0) ? 21'h20 : 21'($urandom_range(9, 13));
      end else if (r < 50) begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
      end else if (r < 62) begin
        case ($urandom_range(0, 2))
          0: cp = 21'($urandom_range(21'h4E00, 21'h9FFF));
          1: cp = 21'($urandom_range(21'h3400, 21'h4DBF));
          default: cp = 21'($urandom_range(21'hF900, 21'hFAFF));
        endcase
      end else if (r < 72) begin
        cp = ($urandom_range(0, 1) != 0) ? 21'($urandom_range(21'h2000, 21'h206F))
                                         : 21'($urandom_range(21'hFF00, 21'hFFEF));
      end else if (r < 82) begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0: cp = 21'($urandom_range(21'h20000, 21'h2CEAF));
          1: cp = 21'($urandom_range(21'h2F800, 21'h2FA1F));
          default: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        endcase
      end else begin
        text_buf = {text_buf, 8'($urandom_range(0, 255))};
        continue;
      end
      add_cp(cp);
    end
    // now and then the text ends inside a multi-byte sequence
    if ($urandom_range(0, 99) < 12) begin
      text_buf = {text_buf, (($urandom_range(0, 1) != 0) ? 8'hE4 : 8'hF0)};
      repeat ($urandom_range(0, 2)) text_buf = {text_buf, 8'h80 | 8'($urandom_range(0, 63))};
    end
    flush_text();
  endtask

  // Stimulus build, reset and end of run
  initial begin
    // Directed: case lowering, zero code point, space, ASCII punctuation
    text_buf = '{8'h41, 8'h00, 8'h20, 8'h21,
                 // CJK, then punctuation whose continuations carry odd top bits
                 8'hE4, 8'hB8, 8'h80, 8'hE2, 8'hC0, 8'hD4,
                 // invalid leads; the second one ends the text with a token open
                 8'h80, 8'hFF};
    flush_text();
    // overlong space, largest value, then four-byte CJK with end of text
    text_buf = '{8'hC0, 8'hA0, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                 8'hF0, 8'hA0, 8'h80, 8'h80};
    flush_text();
    // surrogate value, then a sequence cut short at end of text
    text_buf = '{8'hED, 8'hA0, 8'h80, 8'hE4, 8'hB8};
    flush_text();
    while (text_q.size() < 150) add_random_text();

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (text_q.size() != 0 || tokens_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("utf8_cjk_punct_pretokenizer regression: pass");
    end else begin
      $display("utf8_cjk_punct_pretokenizer regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("utf8_cjk_punct_pretokenizer regression: fail");
    $finish;
  end

  // Input driver: holds a beat until taken, then offers the next or idles
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_beats != beats_seen) begin
      beats_seen = in_beats;
      if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= text_q[0].data;
        in_tlast  <= text_q[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!stall_done && in_beats >= 40) begin
      out_tready <= 1'b0;
      stall_done = 1'b1;
      stall_left = 300;
    end else begin
      out_tready <= calm || $urandom_range(0, 99) >= 7;
    end
  end

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk) begin : sample
    token_beat_t want;
    if (rst_n && in_tvalid && in_tready) begin
      split_byte(in_tdata, in_tlast);
      void'(text_q.pop_front());
      in_beats++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        flag_error($sformatf("unexpected beat kind %0d byte %02h last %0b",
                             out_tuser, out_tdata, out_tlast));
      end else begin
        want = tokens_due.pop_front();
        if (out_tuser !== want.kind || out_tdata !== want.data || out_tlast !== want.last)
          flag_error($sformatf("beat kind %0d byte %02h last %0b, want %0d %02h %0b",
                               out_tuser, out_tdata, out_tlast,
                               want.kind, want.data, want.last));
      end
    end
  end

endmodule

FILE: sim.f
rtl/ucpt_pkg.sv
rtl/ucpt_front.sv
rtl/ucpt_queue.sv
rtl/ucpt_back.sv
rtl/utf8_cjk_punct_pretokenizer.sv
dv/tb_top.sv
